### design/lmpk_pkg.sv
// Shared types and constants for the multiplexed LED driver with key scan.
`default_nettype none

package lmpk_pkg;

   typedef enum logic [1:0] {
      ACT_TICK      = 2'd0,
      ACT_WRITE_SEG = 2'd1,
      ACT_WRITE_MSK = 2'd2,
      ACT_WRITE_COM = 2'd3
   } lmpk_action_type;

   localparam int unsigned CsrIndexW = 3;

   localparam logic [CsrIndexW-1:0] CSR_BRIGHTNESS    = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_BREATH_LEVEL  = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_BREATH_ENABLE = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_FILTER_ENABLE = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_FILTER_COUNT  = 3'd4;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] breath_level;
      logic       breath_enable;
      logic       filter_enable;
      logic [5:0] filter_count;
   } lmpk_cfg_type;

   typedef struct packed {
      logic [7:0] segment_pins;
      logic       segment_drive_on;
      logic [7:0] common_pins;
      logic [7:0] key_value;
   } lmpk_result_type;

endpackage

`default_nettype wire

### design/lmpk_engine.sv
// Scan state, pattern tables and per-beat next-state logic of the LED driver.
`default_nettype none

module lmpk_engine #(
   parameter int unsigned PWM_TOP = 40,
   parameter int unsigned DIGITS  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [1:0]            action,
   input  wire logic [3:0]            digit_index,
   input  wire logic [7:0]            write_data,
   input  wire logic [7:0]            key_pins,
   input  wire lmpk_pkg::lmpk_cfg_type cfg,
   output lmpk_pkg::lmpk_result_type  result
);
   import lmpk_pkg::*;

   localparam int unsigned DigitW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [7:0] TopSlot = 8'(PWM_TOP);
   localparam logic [9:0] TopMinusOne = 10'(PWM_TOP - 1);
   localparam logic [DigitW-1:0] LastDigit = DigitW'(DIGITS - 1);
   localparam logic [4:0] DigitCount = 5'(DIGITS);

   logic [7:0] segment_table [DIGITS];
   logic [7:0] mask_table [DIGITS];
   logic [7:0] common_table [DIGITS];

   logic [7:0]        slot_ff, slot_in;
   logic [DigitW-1:0] digit_ff, digit_in;
   logic [7:0]        breath_ff, breath_in;
   logic [7:0]        keys_ff, keys_in;
   logic [7:0]        prev_ff, prev_in;
   logic [5:0]        stable_ff, stable_in;
   logic [7:0]        seg_ff, seg_in;
   logic              driven_ff, driven_in;
   logic [7:0]        com_ff, com_in;
   logic [7:0]        mask_cur_ff, mask_cur_in;

   lmpk_action_type   act;
   logic              index_ok;
   logic [DigitW-1:0] widx;
   logic [DigitW-1:0] digit_next;
   logic [9:0]        limit_raw;
   logic [9:0]        limit;
   logic [7:0]        bright;
   logic [7:0]        slot_next;
   logic [7:0]        breath_clamped;
   logic [7:0]        next_seg, next_mask, next_com;

   assign act      = lmpk_action_type'(action);
   assign index_ok = {1'b0, digit_index} < DigitCount;
   assign widx     = digit_index[DigitW-1:0];
   assign digit_next = (digit_ff == LastDigit) ? '0 : digit_ff + 1'b1;
   assign slot_next  = slot_ff + 8'd1;

   // A write to the entry about to be shown is forwarded.
   always_comb begin
      next_seg  = segment_table[digit_next];
      next_mask = mask_table[digit_next];
      next_com  = common_table[digit_next];
      if (index_ok && widx == digit_next) begin
         if (act == ACT_WRITE_SEG) next_seg = write_data;
         if (act == ACT_WRITE_MSK) next_mask = write_data;
         if (act == ACT_WRITE_COM) next_com = write_data;
      end
   end

   always_comb begin
      limit_raw = TopMinusOne - (cfg.filter_enable ? {4'd0, cfg.filter_count} : 10'd0);
      if (limit_raw[9] || limit_raw == 10'd0) begin
         limit = 10'd1;
      end else begin
         limit = limit_raw;
      end
      if ({2'b00, cfg.brightness} > limit) begin
         bright = limit[7:0];
      end else if (cfg.brightness == 8'd0) begin
         bright = 8'd1;
      end else begin
         bright = cfg.brightness;
      end
      breath_clamped = (cfg.breath_level < bright) ? cfg.breath_level : bright;
   end

   always_comb begin
      slot_in     = slot_ff;
      digit_in    = digit_ff;
      breath_in   = breath_ff;
      keys_in     = keys_ff;
      prev_in     = prev_ff;
      stable_in   = stable_ff;
      seg_in      = seg_ff;
      driven_in   = driven_ff;
      com_in      = com_ff;
      mask_cur_in = mask_cur_ff;
      unique case (act)
         ACT_TICK: begin
            if (slot_ff == TopSlot) begin
               slot_in     = 8'd0;
               breath_in   = breath_clamped;
               digit_in    = digit_next;
               driven_in   = 1'b1;
               mask_cur_in = next_mask;
               com_in      = next_com;
               if (cfg.breath_enable && breath_clamped == 8'd0) begin
                  seg_in = next_seg & ~next_mask;
               end else begin
                  seg_in = next_seg;
               end
            end else begin
               slot_in = slot_next;
               priority if (slot_next >= bright) begin
                  priority if (slot_next == bright) begin
                     com_in    = 8'd0;
                     driven_in = 1'b0;
                  end else if (cfg.filter_enable) begin
                     if (key_pins == prev_ff) begin
                        if (stable_ff < cfg.filter_count) begin
                           stable_in = stable_ff + 6'd1;
                        end else begin
                           keys_in = key_pins;
                        end
                     end else begin
                        prev_in   = key_pins;
                        stable_in = 6'd0;
                     end
                  end else if (slot_next == TopSlot) begin
                     keys_in = key_pins;
                  end else begin
                  end
               end else if (cfg.breath_enable && slot_next == breath_ff) begin
                  seg_in = seg_ff & ~mask_cur_ff;
               end else begin
               end
            end
         end
         ACT_WRITE_MSK: begin
            if (index_ok && widx == digit_ff) mask_cur_in = write_data;
         end
         ACT_WRITE_SEG, ACT_WRITE_COM: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(DIGITS); i++) begin
            segment_table[i] <= 8'd0;
            mask_table[i]    <= 8'd0;
            common_table[i]  <= 8'd0;
         end
      end else if (step && act != ACT_TICK && index_ok) begin
         if (act == ACT_WRITE_SEG) segment_table[widx] <= write_data;
         if (act == ACT_WRITE_MSK) mask_table[widx] <= write_data;
         if (act == ACT_WRITE_COM) common_table[widx] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= 8'd0;
         digit_ff    <= '0;
         breath_ff   <= 8'd0;
         keys_ff     <= 8'd0;
         prev_ff     <= 8'd0;
         stable_ff   <= 6'd0;
         seg_ff      <= 8'd0;
         driven_ff   <= 1'b1;
         com_ff      <= 8'd0;
         mask_cur_ff <= 8'd0;
      end else if (step) begin
         slot_ff     <= slot_in;
         digit_ff    <= digit_in;
         breath_ff   <= breath_in;
         keys_ff     <= keys_in;
         prev_ff     <= prev_in;
         stable_ff   <= stable_in;
         seg_ff      <= seg_in;
         driven_ff   <= driven_in;
         com_ff      <= com_in;
         mask_cur_ff <= mask_cur_in;
      end
   end

   assign result.segment_pins     = driven_in ? seg_in : 8'd0;
   assign result.segment_drive_on = driven_in;
   assign result.common_pins      = com_in;
   assign result.key_value        = keys_in;

   slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= TopSlot)
      else $error("Slot counter ran past the top slot.");

   digit_in_range: assert property (@(posedge clock) disable iff (reset)
      5'(digit_ff) < DigitCount)
      else $error("Digit select out of range.");

   commons_off_when_released: assert property (@(posedge clock) disable iff (reset)
      !driven_ff |-> com_ff == 8'd0)
      else $error("Commons driven while segment pins are released.");

   wrap_drives_segments: assert property (@(posedge clock) disable iff (reset)
      step && act == ACT_TICK && slot_ff == TopSlot |=> driven_ff && slot_ff == 8'd0)
      else $error("Wrap did not restart the digit with segments driven.");

endmodule

`default_nettype wire

### design/led_mux_pwm_key_scanner_top.sv
// Top level of the multiplexed LED driver with PWM dimming and key scan.
`default_nettype none

// Each request beat is a timer tick or a write to the segment, breath mask or
// common table, and each produces exactly one response beat holding the pin
// state after it. The block takes one beat per clock cycle while the response
// side does not stall. A beat passes an input register, the scan logic and a
// result register, whose output is held while the response side stalls.
// Configuration registers are written through the csr_ channel at any cycle
// and take effect on the next processed beat.
module led_mux_pwm_key_scanner_top #(
   parameter int unsigned PWM_TOP = 40,
   parameter int unsigned DIGITS  = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_action,
   input  wire logic [3:0]                       req_digit_index,
   input  wire logic [7:0]                       req_write_data,
   input  wire logic [7:0]                       req_key_pins,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_segment_pins,
   output logic                                  rsp_segment_drive_on,
   output logic [7:0]                            rsp_common_pins,
   output logic [7:0]                            rsp_key_value,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lmpk_pkg::CsrIndexW-1:0]   csr_index,
   input  wire logic [7:0]                       csr_wdata
);
   import lmpk_pkg::*;

   lmpk_cfg_type    cfg_ff, cfg_in;
   lmpk_result_type result;
   lmpk_result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] action_ff;
   logic [3:0] digit_index_ff;
   logic [7:0] write_data_ff;
   logic [7:0] key_pins_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       step;
   logic       req_fire;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BRIGHTNESS:    cfg_in.brightness    = csr_wdata;
            CSR_BREATH_LEVEL:  cfg_in.breath_level  = csr_wdata;
            CSR_BREATH_ENABLE: cfg_in.breath_enable = csr_wdata[0];
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_wdata[0];
            CSR_FILTER_COUNT:  cfg_in.filter_count  = csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness    <= 8'd1;
         cfg_ff.breath_level  <= 8'd0;
         cfg_ff.breath_enable <= 1'b0;
         cfg_ff.filter_enable <= 1'b0;
         cfg_ff.filter_count  <= 6'd3;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff      <= req_action;
         digit_index_ff <= req_digit_index;
         write_data_ff  <= req_write_data;
         key_pins_ff    <= req_key_pins;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   lmpk_engine #(
      .PWM_TOP (PWM_TOP),
      .DIGITS  (DIGITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .action      (action_ff),
      .digit_index (digit_index_ff),
      .write_data  (write_data_ff),
      .key_pins    (key_pins_ff),
      .cfg         (cfg_ff),
      .result      (result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_segment_pins     = rsp_ff.segment_pins;
   assign rsp_segment_drive_on = rsp_ff.segment_drive_on;
   assign rsp_common_pins      = rsp_ff.common_pins;
   assign rsp_key_value        = rsp_ff.key_value;

   held_beat_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff)
      else $error("Held request beat was dropped.");

   step_yields_response: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("Processed beat produced no response.");

   released_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.segment_drive_on |-> rsp_ff.segment_pins == 8'd0)
      else $error("Released segment pins show a nonzero pattern.");

endmodule

`default_nettype wire
